// ===== sv/lblr_pkg.sv =====
// shared types and constants for the leveled byte log ring
// used by lblr_front, lblr_queue, lblr_back and leveled_byte_log_ring
package lblr_pkg;

	localparam int LOG_BYTES = 16384;
	localparam int ADDR_W    = $clog2(LOG_BYTES);
	localparam int FILL_W    = ADDR_W + 1;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// request codes (s_tuser)
	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// result kinds (m_tuser)
	localparam logic [1:0] KIND_ECHO   = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_BEYOND = 2'd2;

	// configuration register indexes
	localparam logic CFG_CONSOLE = 1'b0;
	localparam logic CFG_DEFAULT = 1'b1;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NL    = 8'h0A;

	// one classified request: bytes to store in order, the trailing ecount
	// of them are echoed to the console
	typedef struct packed {
		logic [1:0]       op;
		logic [5:0][7:0]  wbytes;
		logic [2:0]       wcount;
		logic [1:0]       ecount;
		logic [13:0]      offset;
	} log_cmd_t;

endpackage

// ===== sv/lblr_front.sv =====
// front end: accepts requests, tracks the line prefix state and turns each
// request into a log_cmd_t for the queue; uses lblr_pkg
module lblr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  logic [7:0]        data_byte,
	input  logic              end_of_text,
	input  logic [13:0]       read_offset,
	input  logic [3:0]        console_level,
	input  logic [2:0]        default_level,
	input  logic              q_full,
	output logic              q_push,
	output lblr_pkg::log_cmd_t q_data
);
	import lblr_pkg::*;

	logic [2:0]  level_q;
	logic        known_q;
	logic [15:0] pend_q;
	logic [1:0]  pcount_q;

	logic        accept;
	logic [1:0]  pc_eff;
	logic [1:0]  m;
	logic [7:0]  list0, list1, list2;
	logic        ok, use_default, prefix_done;
	logic [7:0]  digit_off;
	logic [2:0]  lvl_next;
	logic        known_next;
	logic [15:0] pend_next;
	logic [1:0]  pcount_next;
	log_cmd_t    cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pc_eff = (pcount_q > 2'd2) ? 2'd2 : pcount_q;
		m      = pc_eff + 2'd1;
		list0  = (pc_eff == 2'd0) ? data_byte : pend_q[7:0];
		list1  = (pc_eff == 2'd1) ? data_byte : pend_q[15:8];
		list2  = data_byte;
		ok = (list0 == CH_LT)
			&& ((m < 2'd2) || (list1 >= CH_ZERO && list1 <= CH_SEVEN))
			&& ((m < 2'd3) || (list2 == CH_GT));
		prefix_done = ok && (m == 2'd3);
		use_default = !ok || (!prefix_done && end_of_text);
		digit_off   = list1 - CH_ZERO;

		lvl_next    = level_q;
		known_next  = known_q;
		pend_next   = pend_q;
		pcount_next = pcount_q;

		cmd        = '0;
		cmd.op     = req_type;
		cmd.offset = read_offset;

		if (known_q) begin
			cmd.wbytes[0] = data_byte;
			cmd.wcount    = 3'd1;
			cmd.ecount    = ({1'b0, level_q} < console_level) ? 2'd1 : 2'd0;
			known_next    = (data_byte != CH_NL);
		end else if (use_default) begin
			lvl_next      = default_level;
			cmd.wbytes[0] = CH_LT;
			cmd.wbytes[1] = CH_ZERO + {5'd0, default_level};
			cmd.wbytes[2] = CH_GT;
			cmd.wbytes[3] = list0;
			cmd.wbytes[4] = list1;
			cmd.wbytes[5] = list2;
			cmd.wcount    = 3'd3 + {1'b0, m};
			cmd.ecount    = ({1'b0, default_level} < console_level) ? m : 2'd0;
			// a newline among the message bytes reopens the line
			known_next    = !((list0 == CH_NL) || (m >= 2'd2 && list1 == CH_NL)
				|| (m == 2'd3 && list2 == CH_NL));
			pend_next     = '0;
			pcount_next   = 2'd0;
		end else if (prefix_done) begin
			lvl_next      = digit_off[2:0];
			known_next    = 1'b1;
			cmd.wbytes[0] = list0;
			cmd.wbytes[1] = list1;
			cmd.wbytes[2] = list2;
			cmd.wcount    = 3'd3;
			pend_next     = '0;
			pcount_next   = 2'd0;
		end else begin
			// still collecting a possible prefix
			pcount_next = m;
			pend_next   = {(m == 2'd2) ? list1 : 8'd0, list0};
		end
	end

	assign q_data = cmd;
	assign q_push = accept && (req_type == REQ_APPEND || req_type == REQ_READ
		|| req_type == REQ_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			known_q  <= 1'b0;
			pend_q   <= '0;
			pcount_q <= '0;
		end else if (accept && req_type == REQ_APPEND) begin
			level_q  <= lvl_next;
			known_q  <= known_next;
			pend_q   <= pend_next;
			pcount_q <= pcount_next;
		end
	end

endmodule

// ===== sv/lblr_queue.sv =====
// short command queue between front and back end
// holds lblr_pkg::log_cmd_t entries
module lblr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lblr_pkg::log_cmd_t push_data,
	output logic               full,
	input  logic               pop,
	output lblr_pkg::log_cmd_t head,
	output logic               head_valid
);
	import lblr_pkg::*;

	log_cmd_t             entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wptr_q, rptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 do_push, do_pop;

	assign full       = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lblr_back.sv =====
// back end: ring memory, pointers and counters, result register
// executes queued log_cmd_t entries; uses lblr_pkg
module lblr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  lblr_pkg::log_cmd_t head,
	input  logic               head_valid,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_kind,
	output logic [7:0]         out_byte,
	output logic [14:0]        fill_level,
	output logic [31:0]        total_logged,
	output logic               out_last
);
	import lblr_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WR   = 2'd1;
	localparam logic [1:0] ST_ECHO = 2'd2;
	localparam logic [1:0] ST_RD   = 2'd3;

	logic [7:0]        ring_mem [LOG_BYTES];
	logic [7:0]        rdata_q;

	logic [1:0]        state_q;
	logic [2:0]        idx_q;
	logic [ADDR_W-1:0] oldest_q;
	logic [FILL_W-1:0] fill_q;
	logic [31:0]       total_q;

	logic              oval_q;
	logic [1:0]        okind_q;
	logic [7:0]        obyte_q;
	logic [14:0]       ofill_q;
	logic [31:0]       ototal_q;
	logic              olast_q;

	logic              out_free;
	logic [31:0]       wr_sum, rd_sum, fill32;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              in_range;
	logic              ring_full;
	logic [2:0]        echo_idx;
	logic              emit;
	logic [1:0]        emit_kind;
	logic [7:0]        emit_byte;
	logic              emit_last;

	assign out_free  = !oval_q || out_ready;
	assign fill32    = 32'(fill_q);
	assign wr_sum    = 32'(oldest_q) + fill32;
	assign wr_addr   = wr_sum[ADDR_W-1:0];
	assign rd_sum    = 32'(oldest_q) + 32'(head.offset);
	assign rd_addr   = rd_sum[ADDR_W-1:0];
	assign in_range  = 32'(head.offset) < fill32;
	assign ring_full = (fill_q == FILL_W'(LOG_BYTES));
	assign echo_idx  = head.wcount - {1'b0, head.ecount} + idx_q;

	always_comb begin
		emit      = 1'b0;
		emit_kind = KIND_ECHO;
		emit_byte = '0;
		emit_last = 1'b0;
		q_pop     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && !(head.op == REQ_READ)
						&& !(head.op == REQ_APPEND && head.wcount != 3'd0)) begin
					q_pop = 1'b1;
				end
			end
			ST_WR: begin
				q_pop = (idx_q == head.wcount - 3'd1) && (head.ecount == 2'd0);
			end
			ST_ECHO: begin
				emit      = out_free;
				emit_byte = head.wbytes[echo_idx];
				emit_last = ({1'b0, idx_q[1:0]} == {1'b0, head.ecount} - 3'd1);
				q_pop     = emit && emit_last;
			end
			ST_RD: begin
				emit      = out_free;
				emit_kind = in_range ? KIND_READ : KIND_BEYOND;
				emit_byte = in_range ? rdata_q : 8'd0;
				emit_last = 1'b1;
				q_pop     = emit;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// ring write and registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_WR) begin
			ring_mem[wr_addr] <= head.wbytes[idx_q];
		end
		rdata_q <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			oldest_q <= '0;
			fill_q   <= '0;
			total_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (head_valid) begin
						case (head.op)
							REQ_APPEND: begin
								if (head.wcount != 3'd0) begin
									state_q <= ST_WR;
								end
							end
							REQ_READ: begin
								state_q <= ST_RD;
							end
							REQ_CLEAR: begin
								oldest_q <= '0;
								fill_q   <= '0;
								total_q  <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WR: begin
					// oldest byte drops out once the ring is full
					if (ring_full) begin
						oldest_q <= oldest_q + 1'b1;
					end else begin
						fill_q <= fill_q + 1'b1;
					end
					total_q <= total_q + 32'd1;
					if (idx_q == head.wcount - 3'd1) begin
						idx_q   <= '0;
						state_q <= (head.ecount == 2'd0) ? ST_IDLE : ST_ECHO;
					end else begin
						idx_q <= idx_q + 3'd1;
					end
				end
				ST_ECHO: begin
					if (emit) begin
						idx_q <= idx_q + 3'd1;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RD: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (emit) begin
			oval_q <= 1'b1;
		end else if (out_ready) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			okind_q  <= emit_kind;
			obyte_q  <= emit_byte;
			ofill_q  <= fill32[14:0];
			ototal_q <= total_q;
			olast_q  <= emit_last;
		end
	end

	assign out_valid    = oval_q;
	assign out_kind     = okind_q;
	assign out_byte     = obyte_q;
	assign fill_level   = ofill_q;
	assign total_logged = ototal_q;
	assign out_last     = olast_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LOG_BYTES))
		else $error("fill count beyond ring size");
	a_echo_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ECHO |-> head_valid && head.ecount != 2'd0)
		else $error("echo state without echo bytes");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> head_valid)
		else $error("pop from empty queue");
	a_oldest_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR && !ring_full) |=> $stable(oldest_q))
		else $error("oldest position moved before ring was full");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && !out_ready) |-> !emit)
		else $error("result overwritten while stalled");

endmodule

// ===== sv/leveled_byte_log_ring.sv =====
// leveled byte log ring, top level: configuration registers and wiring of
// front end, command queue and back end; uses lblr_pkg
// order: a request is written into the command queue on its transfer; an
//   append then passes dispatch, one ring write per stored byte (1 to 6) and
//   one result per echoed byte, a read dispatch and one result, a clear only dispatch
// flow: every stored byte goes through the single ring write port; the queue
//   keeps accepting while the back end is busy, until both of its entries are full
// reset: pointers, counters and line state clear, console level 3, default
//   level 4; ring contents are not cleared (never read before written)
module leveled_byte_log_ring (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // data_byte[7:0], read_offset[21:8], zero pad
	input  logic [1:0]  s_tuser,  // req_type
	input  logic        s_tlast,  // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // out_byte[7:0], fill_level[22:8], total_logged[54:23]
	output logic [1:0]  m_tuser,  // out_kind
	output logic        m_tlast,  // last
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import lblr_pkg::*;

	logic [3:0]  console_q;
	logic [2:0]  default_q;

	logic        q_push, q_full, q_pop, head_valid;
	log_cmd_t    push_data, head;

	logic [7:0]  out_byte;
	logic [14:0] fill_level;
	logic [31:0] total_logged;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			console_q <= 4'd3;
			default_q <= 3'd4;
		end else if (cfg_we) begin
			if (cfg_index == CFG_CONSOLE) begin
				console_q <= cfg_data;
			end else if (cfg_index == CFG_DEFAULT) begin
				default_q <= cfg_data[2:0];
			end
		end
	end

	lblr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.req_type      (s_tuser),
		.data_byte     (s_tdata[7:0]),
		.end_of_text   (s_tlast),
		.read_offset   (s_tdata[21:8]),
		.console_level (console_q),
		.default_level (default_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (push_data)
	);

	lblr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head),
		.head_valid (head_valid)
	);

	lblr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.q_pop        (q_pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_kind     (m_tuser),
		.out_byte     (out_byte),
		.fill_level   (fill_level),
		.total_logged (total_logged),
		.out_last     (m_tlast)
	);

	assign m_tdata = {1'b0, total_logged, fill_level, out_byte};

endmodule

// ===== tb/lblr_checker.sv =====
// result checker for leveled_byte_log_ring: follows the input, result and
// configuration ports, predicts every result and compares it field by field
// depends on lblr_pkg for codes and sizes
`timescale 1ns / 1ps

module lblr_checker
	import lblr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // data_byte[7:0], read_offset[21:8], zero pad
	input  logic [1:0]  s_tuser,  // req_type
	input  logic        s_tlast,  // end_of_text
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,  // out_byte[7:0], fill_level[22:8], total_logged[54:23]
	input  logic [1:0]  m_tuser,  // out_kind
	input  logic        m_tlast,  // last
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	output int          failures,
	output int          outstanding
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [14:0] fill;
		logic [31:0] total;
		logic        last;
	} log_result_t;

	logic [7:0]        ring_copy [LOG_BYTES];
	logic [ADDR_W-1:0] oldest;
	logic [FILL_W-1:0] held_total;
	logic [31:0]       logged_total;
	logic [2:0]        line_lvl;
	logic              lvl_known;
	logic [1:0][7:0]   prefix_hold;
	int                prefix_n;
	logic [3:0]        console_lvl;
	logic [2:0]        default_lvl;

	logic [7:0]  console_echo [$];
	log_result_t due_results [$];

	task automatic report(input string msg);
		$display("mismatch at %0t ns: %s", $realtime, msg);
		failures++;
	endtask

	task automatic store_byte(input logic [7:0] b);
		logic [ADDR_W-1:0] addr;
		addr = oldest + held_total[ADDR_W-1:0];
		ring_copy[addr] = b;
		if (held_total < LOG_BYTES)
			held_total++;
		else
			oldest++;
		logged_total++;
	endtask

	task automatic store_text(input logic [7:0] b);
		store_byte(b);
		if ({1'b0, line_lvl} < console_lvl && console_echo.size() < 3)
			console_echo.push_back(b);
		if (b == CH_NL)
			lvl_known = 1'b0;
	endtask

	// no valid prefix: store "<d>" with the default digit, then the held bytes as text
	task automatic store_default(input logic [2:0][7:0] seq, input int n);
		line_lvl = default_lvl;
		lvl_known = 1'b1;
		store_byte(CH_LT);
		store_byte(CH_ZERO + line_lvl);
		store_byte(CH_GT);
		for (int i = 0; i < n; i++)
			store_text(seq[i]);
		prefix_n = 0;
		prefix_hold = '0;
	endtask

	task automatic predict_append(input logic [7:0] b, input logic eot);
		logic [2:0][7:0] seq;
		int n;
		bit ok;
		console_echo.delete();
		if (lvl_known) begin
			store_text(b);
		end else begin
			n = prefix_n > 2 ? 2 : prefix_n;
			seq[0] = prefix_hold[0];
			seq[1] = prefix_hold[1];
			seq[2] = 8'h00;
			seq[n] = b;
			n++;
			ok = (seq[0] == CH_LT);
			if (n >= 2)
				ok = ok && seq[1] >= CH_ZERO && seq[1] <= CH_SEVEN;
			if (n >= 3)
				ok = ok && seq[2] == CH_GT;
			if (!ok || (n < 3 && eot)) begin
				store_default(seq, n);
			end else if (n == 3) begin
				line_lvl = 3'(seq[1] - CH_ZERO);
				lvl_known = 1'b1;
				store_byte(seq[0]);
				store_byte(seq[1]);
				store_byte(seq[2]);
				prefix_n = 0;
				prefix_hold = '0;
			end else begin
				prefix_n = n;
				prefix_hold[0] = seq[0];
				prefix_hold[1] = (n == 2) ? seq[1] : 8'h00;
			end
		end
		foreach (console_echo[k])
			due_results.push_back({KIND_ECHO, console_echo[k], held_total, logged_total,
				k == console_echo.size() - 1});
	endtask

	task automatic predict_read(input logic [ADDR_W-1:0] off);
		logic [ADDR_W-1:0] addr;
		addr = oldest + off;
		if ({1'b0, off} < held_total)
			due_results.push_back({KIND_READ, ring_copy[addr], held_total, logged_total, 1'b1});
		else
			due_results.push_back({KIND_BEYOND, 8'h00, held_total, logged_total, 1'b1});
	endtask

	task automatic check_result();
		log_result_t r;
		if (due_results.size() == 0) begin
			report("result transfer with nothing expected");
		end else begin
			r = due_results.pop_front();
			if (m_tuser != r.kind)
				report($sformatf("out_kind %0d, expected %0d", m_tuser, r.kind));
			if (m_tdata[7:0] != r.data)
				report($sformatf("out_byte %02h, expected %02h", m_tdata[7:0], r.data));
			if (m_tdata[22:8] != r.fill)
				report($sformatf("fill_level %0d, expected %0d", m_tdata[22:8], r.fill));
			if (m_tdata[54:23] != r.total)
				report($sformatf("total_logged %0d, expected %0d", m_tdata[54:23], r.total));
			if (m_tlast != r.last)
				report($sformatf("last %0b, expected %0b", m_tlast, r.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest = '0;
			held_total = '0;
			logged_total = '0;
			line_lvl = '0;
			lvl_known = 1'b0;
			prefix_hold = '0;
			prefix_n = 0;
			console_lvl = 4'd3;
			default_lvl = 3'd4;
			due_results.delete();
			outstanding = 0;
			failures = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (cfg_we) begin
				if (cfg_index == CFG_CONSOLE)
					console_lvl = cfg_data;
				else
					default_lvl = cfg_data[2:0];
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					REQ_APPEND: predict_append(s_tdata[7:0], s_tlast);
					REQ_READ:   predict_read(s_tdata[21:8]);
					REQ_CLEAR: begin
						oldest = '0;
						held_total = '0;
						logged_total = '0;
					end
					default: ;
				endcase
			end
			outstanding = due_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// top of the leveled_byte_log_ring testbench: clock, reset, stimulus phases
// and verdict; results are judged by lblr_checker; uses lblr_pkg
`timescale 1ns / 1ps

module testbench;
	import lblr_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 45;
	localparam int SETTLE_CYCLES = 40;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // data_byte[7:0], read_offset[21:8], zero pad
	logic [1:0]  s_tuser = '0;  // req_type
	logic        s_tlast = 1'b0;  // end_of_text
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;  // out_byte[7:0], fill_level[22:8], total_logged[54:23]
	logic [1:0]  m_tuser;  // out_kind
	logic        m_tlast;  // last
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [3:0]  cfg_data = '0;

	int log_failures;
	int log_outstanding;
	int src_idle = 0;
	int snk_stall = 0;
	int sent_items = 0;
	bit hold_go = 1'b0;
	logic hold_on;

	leveled_byte_log_ring uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lblr_checker log_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(log_failures), .outstanding(log_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= !hold_on && ($urandom_range(0, 99) >= snk_stall);
	end

	// one long receiver hold-off so the block backs up into its input
	initial begin
		hold_on = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (400) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		#4_000_000;
		$display("FAIL leveled_byte_log_ring");
		$finish;
	end

	task automatic send(input logic [1:0] req, input logic [7:0] b, input logic eot,
			input logic [13:0] off);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tlast <= eot;
		s_tdata <= {2'b00, off, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_items++;
	endtask

	task automatic append_byte(input logic [7:0] b, input logic eot);
		send(REQ_APPEND, b, eot, 14'($urandom_range(0, 16383)));
	endtask

	task automatic send_text(input string s, input bit eot_at_end);
		for (int i = 0; i < s.len(); i++)
			append_byte(s[i], eot_at_end && i == s.len() - 1);
	endtask

	task automatic send_read(input logic [13:0] off);
		send(REQ_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), off);
	endtask

	// stop offering and let every expected result and trailing store drain
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (log_outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly well-formed lines, with missing, broken and cut-short prefixes mixed in
	task automatic random_line();
		int shape;
		int body_len;
		int tail;
		shape = $urandom_range(0, 99);
		body_len = $urandom_range(0, 5);
		if (shape < 60) begin
			append_byte(CH_LT, 1'b0);
			append_byte(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
			append_byte(CH_GT, 1'b0);
		end else if (shape < 86 && shape >= 72) begin
			append_byte(CH_LT, 1'b0);
			if ($urandom_range(0, 1)) begin
				append_byte(8'($urandom_range(0, 255)), 1'b0);
			end else begin
				append_byte(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
				append_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		end else if (shape >= 86) begin
			// text ends before the prefix is complete
			if ($urandom_range(0, 1)) begin
				append_byte(CH_LT, 1'b1);
			end else begin
				append_byte(CH_LT, 1'b0);
				append_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
			end
			return;
		end
		for (int i = 0; i < body_len; i++)
			append_byte(8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
				: $urandom_range(32, 126)), 1'b0);
		tail = $urandom_range(0, 9);
		if (tail < 8)
			append_byte(CH_NL, 1'b1);
		else if (tail == 8)
			append_byte(8'($urandom_range(32, 126)), 1'b1);
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			random_line();
		else if (pick < 85)
			send_read(14'($urandom_range(0, 3) == 0 ? $urandom_range(0, 16383)
				: $urandom_range(0, 200)));
		else if (pick < 89)
			send(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				14'($urandom_range(0, 16383)));
		else if (pick < 94)
			send(REQ_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				14'($urandom_range(0, 16383)));
		else
			send(REQ_APPEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				14'($urandom_range(0, 16383)));
	endtask

	task automatic run_phase(input int src, input int snk, input logic [3:0] cons,
			input logic [3:0] dflt, input bit with_hold);
		int start;
		quiesce();
		write_reg(CFG_CONSOLE, cons);
		write_reg(CFG_DEFAULT, dflt);
		src_idle = src;
		snk_stall = snk;
		if (with_hold)
			hold_go = 1'b1;
		start = sent_items;
		while (sent_items - start < PHASE_ITEMS)
			random_item();
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels: console 3, default 4
		send_read(14'd0);
		send_text("<2>\377\n", 1'b1);
		append_byte("z", 1'b0);
		append_byte(8'h00, 1'b0);
		append_byte(CH_NL, 1'b1);

		quiesce();
		write_reg(CFG_CONSOLE, 4'd5);
		write_reg(CFG_DEFAULT, 4'd1);
		// bad closing char: default prefix, then three echoed bytes from one transfer
		send_text("<5x", 1'b1);
		append_byte(CH_NL, 1'b1);
		// text ends after a lone '<', the following "<7>" is plain message text
		append_byte(CH_LT, 1'b1);
		send_text("<7>\n", 1'b1);
		send_text("<7>\n", 1'b1);
		send_read(14'd0);
		send_read(14'h3FFF);
		send(REQ_CLEAR, 8'hFF, 1'b1, 14'h3FFF);
		send(REQ_UNUSED, 8'h00, 1'b0, 14'd0);
		send_read(14'd0);

		run_phase(0, 0, 4'd8, 4'd0, 1'b1);
		run_phase(48, 0, 4'd0, 4'd7, 1'b0);
		run_phase(0, 48, 4'd15, 4'd3, 1'b0);
		run_phase(8, 8, 4'd6, 4'd15, 1'b0);

		quiesce();
		if (log_failures == 0)
			$display("PASS leveled_byte_log_ring");
		else
			$display("FAIL leveled_byte_log_ring");
		$finish;
	end

endmodule
